// ===== hdl/srl_pkg.sv =====
// Shared types and constants for the semaphore and recursive lock unit.
`default_nettype none
package srl_pkg;

  localparam int MAX_THREADS = 256;
  localparam int PTR_W       = $clog2(MAX_THREADS);
  localparam int FILL_W      = $clog2(MAX_THREADS + 1);
  localparam int TID_W       = 8;
  localparam int TID_NUM     = 1 << TID_W;
  localparam int CNT_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // result status codes
  localparam logic [2:0] ST_GRANTED   = 3'd0;
  localparam logic [2:0] ST_QUEUED    = 3'd1;
  localparam logic [2:0] ST_RELEASED  = 3'd2;
  localparam logic [2:0] ST_ERROR     = 3'd3;
  localparam logic [2:0] ST_SATURATED = 3'd4;

  // request operations
  localparam logic FUNC_DOWN = 1'b0;
  localparam logic FUNC_UP   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_COUNT = 2'd1;

  typedef struct packed {
    logic ld_req;
    logic exec;
  } srl_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/srl_ctrl.sv =====
// Controller: transaction sequencing and output valid tracking.
`default_nettype none
module srl_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output srl_pkg::srl_cmd_t     cmd
);
  import srl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.ld_req = 1'b0;
    cmd.exec   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_req = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || out_ready) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== hdl/srl_dp.sv =====
// Datapath: count, owner, waiter ring, waiting marks and result register.
`default_nettype none
module srl_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire srl_pkg::srl_cmd_t             cmd,
  input  wire logic                          in_func,
  input  wire logic [srl_pkg::TID_W-1:0]     in_thread_id,
  input  wire logic                          cfg_we,
  input  wire logic [srl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [srl_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [2:0]                         out_status,
  output logic                               out_woken_valid,
  output logic [srl_pkg::TID_W-1:0]          out_woken_thread
);
  import srl_pkg::*;

  logic                 lock_mode_r;
  logic [CNT_W-1:0]     avail_r, avail_nxt;
  logic                 owner_valid_r, owner_valid_nxt;
  logic [TID_W-1:0]     owner_id_r, owner_id_nxt;
  logic [CNT_W-1:0]     nest_r, nest_nxt;
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [TID_NUM-1:0]   mark_r;

  logic                 func_r;
  logic [TID_W-1:0]     tid_r;
  logic                 mark_rd_r;
  logic [TID_W-1:0]     ring_rd_r;
  logic [TID_W-1:0]     ring [MAX_THREADS];

  logic [2:0]           status_r, status_nxt;
  logic                 wv_r, wv_nxt;
  logic [TID_W-1:0]     wt_r, wt_nxt;

  logic                 enq, deq, full, holder, marked;
  logic [FILL_W-1:0]    slot_sum;
  logic [PTR_W-1:0]     slot;

  assign full     = (fill_r >= FILL_W'(MAX_THREADS));
  assign holder   = owner_valid_r && (owner_id_r == tid_r);
  assign marked   = mark_rd_r;
  assign slot_sum = FILL_W'(head_r) + fill_r;
  assign slot     = (slot_sum >= FILL_W'(MAX_THREADS)) ?
                    PTR_W'(slot_sum - FILL_W'(MAX_THREADS)) : PTR_W'(slot_sum);

  always_comb begin
    avail_nxt       = avail_r;
    owner_valid_nxt = owner_valid_r;
    owner_id_nxt    = owner_id_r;
    nest_nxt        = nest_r;
    status_nxt      = ST_ERROR;
    enq             = 1'b0;
    deq             = 1'b0;
    if (!lock_mode_r) begin
      if (func_r == FUNC_DOWN) begin
        if (marked) begin
          status_nxt = ST_ERROR;
        end else if (avail_r != '0) begin
          avail_nxt  = avail_r - CNT_W'(1);
          status_nxt = ST_GRANTED;
        end else if (full) begin
          status_nxt = ST_ERROR;
        end else begin
          enq        = 1'b1;
          status_nxt = ST_QUEUED;
        end
      end else begin
        if (fill_r != '0) begin
          deq        = 1'b1;
          status_nxt = ST_RELEASED;
        end else if (avail_r == CNT_MAX) begin
          status_nxt = ST_SATURATED;
        end else begin
          avail_nxt  = avail_r + CNT_W'(1);
          status_nxt = ST_RELEASED;
        end
      end
    end else begin
      if (func_r == FUNC_DOWN) begin
        if (holder) begin
          if (nest_r == CNT_MAX) begin
            status_nxt = ST_SATURATED;
          end else begin
            nest_nxt   = nest_r + CNT_W'(1);
            status_nxt = ST_GRANTED;
          end
        end else if (marked) begin
          status_nxt = ST_ERROR;
        end else if (!owner_valid_r) begin
          owner_valid_nxt = 1'b1;
          owner_id_nxt    = tid_r;
          nest_nxt        = CNT_W'(1);
          status_nxt      = ST_GRANTED;
        end else if (full) begin
          status_nxt = ST_ERROR;
        end else begin
          enq        = 1'b1;
          status_nxt = ST_QUEUED;
        end
      end else begin
        if (!holder) begin
          status_nxt = ST_ERROR;
        end else if (nest_r > CNT_W'(1)) begin
          nest_nxt   = nest_r - CNT_W'(1);
          status_nxt = ST_RELEASED;
        end else if (fill_r != '0) begin
          deq             = 1'b1;
          owner_valid_nxt = 1'b1;
          owner_id_nxt    = ring_rd_r;
          nest_nxt        = CNT_W'(1);
          status_nxt      = ST_RELEASED;
        end else begin
          owner_valid_nxt = 1'b0;
          owner_id_nxt    = '0;
          nest_nxt        = '0;
          status_nxt      = ST_RELEASED;
        end
      end
    end

    wv_nxt   = deq;
    wt_nxt   = deq ? ring_rd_r : '0;
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (enq) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (deq) begin
      fill_nxt = fill_r - FILL_W'(1);
      head_nxt = (head_r == PTR_W'(MAX_THREADS - 1)) ? '0 : head_r + PTR_W'(1);
    end
  end

  // waiter ring: one write port, registered read at the head
  always_ff @(posedge clk) begin
    if (cmd.exec && enq) begin
      ring[slot] <= tid_r;
    end
    ring_rd_r <= ring[head_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      func_r    <= in_func;
      tid_r     <= in_thread_id;
      mark_rd_r <= mark_r[in_thread_id];
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      wv_r     <= wv_nxt;
      wt_r     <= wt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_mode_r   <= 1'b1;
      avail_r       <= CNT_W'(1);
      owner_valid_r <= 1'b0;
      owner_id_r    <= '0;
      nest_r        <= '0;
      head_r        <= '0;
      fill_r        <= '0;
      mark_r        <= '0;
    end else begin
      if (cmd.exec) begin
        avail_r       <= avail_nxt;
        owner_valid_r <= owner_valid_nxt;
        owner_id_r    <= owner_id_nxt;
        nest_r        <= nest_nxt;
        head_r        <= head_nxt;
        fill_r        <= fill_nxt;
        if (enq) begin
          mark_r[tid_r] <= 1'b1;
        end else if (deq) begin
          mark_r[ring_rd_r] <= 1'b0;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LOCK_MODE:  lock_mode_r <= cfg_data[0];
          CFG_INIT_COUNT: avail_r     <= CNT_W'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  assign out_status       = status_r;
  assign out_woken_valid  = wv_r;
  assign out_woken_thread = wt_r;

endmodule
`default_nettype wire

// ===== hdl/semaphore_and_recursive_lock_top.sv =====
// Top level of the semaphore and recursive lock unit.
// Each request transaction is handled first in an accept step, while the waiter
// ring RAM reads the entry at the queue head into its output register, then in
// an execute step that decides and loads the result register. The execute step
// waits only while a previous result still sits unaccepted in the result
// register; a new transaction is accepted only once the last one has executed.
// Configuration writes take effect at once and are meant for idle periods.
`default_nettype none
module semaphore_and_recursive_lock_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_func,
  input  wire logic [srl_pkg::TID_W-1:0]      in_thread_id,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [2:0]                          out_status,
  output logic                                out_woken_valid,
  output logic [srl_pkg::TID_W-1:0]           out_woken_thread,
  input  wire logic                           cfg_we,
  input  wire logic [srl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import srl_pkg::*;

  srl_cmd_t cmd;

  srl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  srl_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_func          (in_func),
    .in_thread_id     (in_thread_id),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_status       (out_status),
    .out_woken_valid  (out_woken_valid),
    .out_woken_thread (out_woken_thread)
  );

  a_wake_is_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_woken_valid) |-> (out_status == ST_RELEASED))
    else $error("wake without release status");

  a_no_wake_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_woken_valid) |-> (out_woken_thread == '0))
    else $error("woken thread id set without wake");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_SATURATED))
    else $error("status code out of range");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted during execute");

endmodule
`default_nettype wire

// ===== tb/sv/semaphore_and_recursive_lock_top_tb.sv =====
// Self-checking testbench for the semaphore and recursive lock unit.
`timescale 1ns / 1ps

module semaphore_and_recursive_lock_top_tb;
  import srl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             woken_v;
    logic [TID_W-1:0] woken_id;
  } sync_outcome_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  func;
    logic [TID_W-1:0]      tid;
    logic                  pinned;
    sync_outcome_t         want;
  } dir_row_t;

  localparam int DIR_ROWS = 28;
  localparam int DIR_IDX_W = $clog2(DIR_ROWS);
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_DOWN, 8'h00, 1'b1, '{ST_GRANTED, 1'b0, 8'h00}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_DOWN, 8'h00, 1'b0, '{ST_GRANTED, 1'b0, 8'h00}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_UP,   8'hff, 1'b1, '{ST_ERROR,   1'b0, 8'h00}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_DOWN, 8'hff, 1'b1, '{ST_QUEUED,  1'b0, 8'h00}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_DOWN, 8'hff, 1'b1, '{ST_ERROR,   1'b0, 8'h00}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_UP,   8'h00, 1'b0, '{ST_GRANTED, 1'b0, 8'h00}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_UP,   8'h00, 1'b1, '{ST_RELEASED, 1'b1, 8'hff}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_UP,   8'hff, 1'b1, '{ST_RELEASED, 1'b0, 8'h00}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_UP,   8'h07, 1'b1, '{ST_ERROR,   1'b0, 8'h00}},
    '{1'b1, CFG_LOCK_MODE, 8'h00, FUNC_DOWN, 8'h00, 1'b0, '{ST_GRANTED, 1'b0, 8'h00}},
    '{1'b1, CFG_INIT_COUNT, 8'h00, FUNC_DOWN, 8'h00, 1'b0, '{ST_GRANTED, 1'b0, 8'h00}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_DOWN, 8'h55, 1'b1, '{ST_QUEUED,  1'b0, 8'h00}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_DOWN, 8'haa, 1'b1, '{ST_QUEUED,  1'b0, 8'h00}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_UP,   8'h01, 1'b1, '{ST_RELEASED, 1'b1, 8'h55}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_UP,   8'h01, 1'b0, '{ST_GRANTED, 1'b0, 8'h00}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_UP,   8'h01, 1'b0, '{ST_GRANTED, 1'b0, 8'h00}},
    '{1'b1, CFG_INIT_COUNT, 8'hff, FUNC_DOWN, 8'h00, 1'b0, '{ST_GRANTED, 1'b0, 8'h00}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_UP,   8'h80, 1'b1, '{ST_SATURATED, 1'b0, 8'h00}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_DOWN, 8'h03, 1'b0, '{ST_GRANTED, 1'b0, 8'h00}},
    '{1'b1, CFG_SPARE,     8'hff, FUNC_DOWN, 8'h00, 1'b0, '{ST_GRANTED, 1'b0, 8'h00}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_UP,   8'h7f, 1'b1, '{ST_RELEASED, 1'b0, 8'h00}},
    '{1'b1, CFG_INIT_COUNT, 8'h00, FUNC_DOWN, 8'h00, 1'b0, '{ST_GRANTED, 1'b0, 8'h00}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_DOWN, 8'h09, 1'b1, '{ST_QUEUED,  1'b0, 8'h00}},
    '{1'b1, CFG_LOCK_MODE, 8'h01, FUNC_DOWN, 8'h00, 1'b0, '{ST_GRANTED, 1'b0, 8'h00}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_DOWN, 8'h09, 1'b1, '{ST_ERROR,   1'b0, 8'h00}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_DOWN, 8'h04, 1'b1, '{ST_GRANTED, 1'b0, 8'h00}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_UP,   8'h04, 1'b1, '{ST_RELEASED, 1'b1, 8'h09}},
    '{1'b0, CFG_LOCK_MODE, 8'h00, FUNC_UP,   8'h09, 1'b0, '{ST_GRANTED, 1'b0, 8'h00}}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_func;
  logic [TID_W-1:0]      in_thread_id;
  logic                  out_valid;
  logic                  out_ready;
  logic [2:0]            out_status;
  logic                  out_woken_valid;
  logic [TID_W-1:0]      out_woken_thread;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // mirror of the unit's state
  logic             lock_mode_q;
  logic [CNT_W-1:0] avail;
  logic             own_v;
  logic [TID_W-1:0] own_id;
  logic [CNT_W-1:0] nest;
  logic [TID_W-1:0] ring_ids [MAX_THREADS];
  int               ring_head;
  int               ring_fill;
  logic             wait_mark [TID_NUM];

  sync_outcome_t awaited [$];
  int            fail_count = 0;
  int            send_idle_pct = 0;
  int            rx_stall_pct = 0;
  int            hold_asked = 0;
  int            cycle_count;

  semaphore_and_recursive_lock_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_thread_id     (in_thread_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_woken_valid  (out_woken_valid),
    .out_woken_thread (out_woken_thread),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic void set_idling(idle_mode_t m);
    case (m)
      IDLE_NONE: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 65; rx_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  rx_stall_pct = 65; end
      default:   begin send_idle_pct = 16; rx_stall_pct = 16; end
    endcase
  endfunction

  function automatic void enqueue_waiter(logic [TID_W-1:0] tid);
    ring_ids[PTR_W'((ring_head + ring_fill) % MAX_THREADS)] = tid;
    ring_fill++;
    wait_mark[tid] = 1'b1;
  endfunction

  function automatic logic [TID_W-1:0] dequeue_waiter();
    logic [TID_W-1:0] tid;
    tid = ring_ids[PTR_W'(ring_head)];
    ring_head = (ring_head + 1) % MAX_THREADS;
    ring_fill--;
    wait_mark[tid] = 1'b0;
    return tid;
  endfunction

  // advance the mirrored state by one request and return its outcome
  function automatic sync_outcome_t apply_request(logic f, logic [TID_W-1:0] tid);
    sync_outcome_t o;
    logic          holder;
    o = '{ST_ERROR, 1'b0, '0};
    holder = own_v && (own_id == tid);
    if (!lock_mode_q) begin
      if (f == FUNC_DOWN) begin
        if (wait_mark[tid]) o.status = ST_ERROR;
        else if (avail != '0) begin
          avail--;
          o.status = ST_GRANTED;
        end else if (ring_fill >= MAX_THREADS) o.status = ST_ERROR;
        else begin
          enqueue_waiter(tid);
          o.status = ST_QUEUED;
        end
      end else begin
        if (ring_fill > 0) begin
          o.woken_id = dequeue_waiter();
          o.woken_v = 1'b1;
          o.status = ST_RELEASED;
        end else if (avail == CNT_MAX) o.status = ST_SATURATED;
        else begin
          avail++;
          o.status = ST_RELEASED;
        end
      end
    end else if (f == FUNC_DOWN) begin
      if (holder) begin
        if (nest == CNT_MAX) o.status = ST_SATURATED;
        else begin
          nest++;
          o.status = ST_GRANTED;
        end
      end else if (wait_mark[tid]) o.status = ST_ERROR;
      else if (!own_v) begin
        own_v = 1'b1;
        own_id = tid;
        nest = CNT_W'(1);
        o.status = ST_GRANTED;
      end else if (ring_fill >= MAX_THREADS) o.status = ST_ERROR;
      else begin
        enqueue_waiter(tid);
        o.status = ST_QUEUED;
      end
    end else begin
      if (!holder) o.status = ST_ERROR;
      else if (nest > 1) begin
        nest--;
        o.status = ST_RELEASED;
      end else if (ring_fill > 0) begin
        o.woken_id = dequeue_waiter();
        o.woken_v = 1'b1;
        own_id = o.woken_id;
        own_v = 1'b1;
        nest = CNT_W'(1);
        o.status = ST_RELEASED;
      end else begin
        own_v = 1'b0;
        own_id = '0;
        nest = '0;
        o.status = ST_RELEASED;
      end
    end
    return o;
  endfunction

  // called and left at a falling edge with no pending assignment
  task automatic offer_request(input logic f, input logic [TID_W-1:0] tid,
                               input logic pinned, input sync_outcome_t pinned_val);
    sync_outcome_t o;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= f;
    in_thread_id <= tid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    o = apply_request(f, tid);
    awaited.push_back(pinned ? pinned_val : o);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaited.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LOCK_MODE) lock_mode_q = val[0];
    else if (idx == CFG_INIT_COUNT) avail = val;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    sync_outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited.size() == 0) begin
        note_failure($sformatf("unexpected transaction: status %0d woken %0b/%02h",
                               out_status, out_woken_valid, out_woken_thread));
      end else begin
        want = awaited.pop_front();
        if (out_status !== want.status || out_woken_valid !== want.woken_v ||
            out_woken_thread !== want.woken_id) begin
          note_failure($sformatf(
            "mismatch: status %0d woken %0b/%02h, expected status %0d woken %0b/%02h",
            out_status, out_woken_valid, out_woken_thread,
            want.status, want.woken_v, want.woken_id));
        end
      end
    end
  end

  initial begin
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_asked) begin
        holds_done = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic             f;
    logic [TID_W-1:0] tid;
    logic [TID_W-1:0] pool [6];
    logic [TID_W-1:0] perm [TID_NUM];
    logic [TID_W-1:0] tmp;
    logic [CFG_DATA_W-1:0] cnt;
    dir_row_t         row;
    int               r;
    int               j;
    int               drain;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_func      = FUNC_DOWN;
    in_thread_id = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_LOCK_MODE;
    cfg_data     = '0;
    lock_mode_q  = 1'b1;
    avail        = CNT_W'(1);
    own_v        = 1'b0;
    own_id       = '0;
    nest         = '0;
    ring_head    = 0;
    ring_fill    = 0;
    for (int i = 0; i < TID_NUM; i++) wait_mark[TID_W'(i)] = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_idling(IDLE_NONE);
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TABLE[DIR_IDX_W'(i)];
      if (row.is_cfg)
        write_register(row.reg_idx, row.reg_val);
      else
        offer_request(row.func, row.tid, row.pinned, row.want);
    end

    // nesting up to saturation, with the receiver held off at first
    set_idling(IDLE_BOTH);
    hold_asked++;
    repeat (257) offer_request(FUNC_DOWN, 8'hc3, 1'b0, '0);
    offer_request(FUNC_DOWN, 8'h3c, 1'b0, '0);
    repeat (255) offer_request(FUNC_UP, 8'hc3, 1'b0, '0);
    offer_request(FUNC_UP, 8'h3c, 1'b0, '0);

    // fill the waiter ring with every thread, then drain it
    set_idling(IDLE_SEND);
    write_register(CFG_LOCK_MODE, 8'h00);
    write_register(CFG_INIT_COUNT, 8'h00);
    for (int i = 0; i < TID_NUM; i++) perm[TID_W'(i)] = TID_W'(i);
    for (int i = TID_NUM - 1; i > 0; i--) begin
      j = int'($urandom_range(i));
      tmp = perm[TID_W'(i)];
      perm[TID_W'(i)] = perm[TID_W'(j)];
      perm[TID_W'(j)] = tmp;
    end
    for (int i = 0; i < TID_NUM; i++) offer_request(FUNC_DOWN, perm[TID_W'(i)], 1'b0, '0);
    offer_request(FUNC_DOWN, TID_W'($urandom_range(255)), 1'b0, '0);
    repeat (TID_NUM + 1) offer_request(FUNC_UP, TID_W'($urandom_range(255)), 1'b0, '0);

    for (int ph = 0; ph < 8; ph++) begin
      set_idling(idle_mode_t'(ph % 4));
      write_register(CFG_LOCK_MODE, CFG_DATA_W'($urandom_range(255)));
      case (ph % 4)
        0:       cnt = 8'h00;
        1:       cnt = 8'hff;
        2:       cnt = 8'h01;
        default: cnt = CFG_DATA_W'($urandom_range(8));
      endcase
      write_register(CFG_INIT_COUNT, cnt);
      for (int k = 0; k < 6; k++) pool[3'(k)] = TID_W'($urandom_range(255));
      repeat (30) begin
        r = int'($urandom_range(99));
        if (r < 10) begin
          f = 1'($urandom_range(1));
          tid = TID_W'($urandom_range(255));
        end else if (lock_mode_q && own_v && r < 45) begin
          f = FUNC_UP;
          tid = own_id;
        end else begin
          f = 1'($urandom_range(1));
          tid = pool[3'($urandom_range(5))];
        end
        offer_request(f, tid, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    drain = 0;
    while (awaited.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (awaited.size() != 0)
      note_failure($sformatf("%0d transactions never returned", awaited.size()));
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/srl_pkg.sv
hdl/srl_ctrl.sv
hdl/srl_dp.sv
hdl/semaphore_and_recursive_lock_top.sv
tb/sv/semaphore_and_recursive_lock_top_tb.sv
